### rtl/bsl_pkg.sv
// Shared types and constants for the source lexer.
// No dependencies.
package bsl_pkg;

  localparam logic [1:0] REC_TEXT  = 2'd0;
  localparam logic [1:0] REC_TOKEN = 2'd1;
  localparam logic [1:0] REC_ERROR = 2'd2;

  localparam logic [1:0] ERR_UNKNOWN = 2'd0;
  localparam logic [1:0] ERR_LONG    = 2'd1;
  localparam logic [1:0] ERR_UNTERM  = 2'd2;

  localparam logic [5:0] TK_END     = 6'd0;
  localparam logic [5:0] TK_NEWLINE = 6'd1;
  localparam logic [5:0] TK_INT     = 6'd2;
  localparam logic [5:0] TK_SYM     = 6'd3;
  localparam logic [5:0] TK_STR     = 6'd4;
  localparam logic [5:0] TK_COMMA   = 6'd5;
  localparam logic [5:0] TK_LPAREN  = 6'd6;
  localparam logic [5:0] TK_RPAREN  = 6'd7;
  localparam logic [5:0] TK_PLUS    = 6'd8;
  localparam logic [5:0] TK_MINUS   = 6'd9;
  localparam logic [5:0] TK_SLASH   = 6'd10;
  localparam logic [5:0] TK_STAR    = 6'd11;
  localparam logic [5:0] TK_EQ      = 6'd12;
  localparam logic [5:0] TK_LT      = 6'd13;
  localparam logic [5:0] TK_GT      = 6'd14;
  localparam logic [5:0] TK_NE      = 6'd15;
  localparam logic [5:0] TK_LE      = 6'd16;
  localparam logic [5:0] TK_GE      = 6'd17;
  localparam logic [5:0] TK_KW0     = 6'd18;

  localparam logic [2:0] CL_IDLE = 3'd0;
  localparam logic [2:0] CL_INT  = 3'd1;
  localparam logic [2:0] CL_SYM  = 3'd2;
  localparam logic [2:0] CL_STR  = 3'd3;
  localparam logic [2:0] CL_LT   = 3'd4;
  localparam logic [2:0] CL_GT   = 3'd5;

  localparam int KW_COUNT = 24;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  tok;
    logic [7:0]  text;
    logic [15:0] ln;
    logic [15:0] col;
    logic [1:0]  err;
  } rec_t;

  // Keyword characters, position 0..7; zero past the end.
  function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [2:0] p);
    logic [63:0] s;
    case (k)
      5'd0:  s = {"mod", 40'd0};
      5'd1:  s = {"shl", 40'd0};
      5'd2:  s = {"shr", 40'd0};
      5'd3:  s = {"if", 48'd0};
      5'd4:  s = {"else", 32'd0};
      5'd5:  s = {"then", 32'd0};
      5'd6:  s = {"while", 24'd0};
      5'd7:  s = {"do", 48'd0};
      5'd8:  s = {"end", 40'd0};
      5'd9:  s = {"until", 24'd0};
      5'd10: s = {"for", 40'd0};
      5'd11: s = {"to", 48'd0};
      5'd12: s = {"step", 32'd0};
      5'd13: s = {"sub", 40'd0};
      5'd14: s = "function";
      5'd15: s = {"declare", 8'd0};
      5'd16: s = {"dim", 40'd0};
      5'd17: s = {"as", 48'd0};
      5'd18: s = {"exit", 32'd0};
      5'd19: s = "continue";
      5'd20: s = {"integer", 8'd0};
      5'd21: s = {"string", 16'd0};
      5'd22: s = {"public", 16'd0};
      5'd23: s = {"private", 8'd0};
      default: s = 64'd0;
    endcase
    return s[63 - 8*p -: 8];
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] k);
    logic [3:0] n;
    n = 4'd8;
    for (int p = 7; p >= 0; p--) begin
      if (kw_char(k, 3'(p)) == 8'd0) n = 4'(p);
    end
    return n;
  endfunction

endpackage

### rtl/basic_source_lexer_unit.sv
// Streaming lexer for a small BASIC dialect: source bytes in, records out.
// Depends on bsl_pkg.
//
// Usage:
//   in_tdata carries one source byte per request; a zero byte ends the input.
//   Each byte yields zero to three records on the out_ channel, the last one
//   flagged by out_tlast. out_tuser is the record kind (text, token, error).
//   A byte is lexed combinationally from the lexer state into a small record
//   buffer of three entries; the buffer drains one record per cycle while
//   out_tready is high. A new byte is taken once the buffer is empty or about
//   to be. The first record of a byte is registered and is presented in the
//   cycle after the byte is taken.
//   Reset (rst_n low, synchronous) empties the buffer and sets line 1,
//   column 0 and the idle lexer state.
//   While out_tready is low the buffered records hold and in_tready stays
//   low once the buffer cannot be emptied this cycle.
module basic_source_lexer_unit #(
  parameter int TEXT_LIMIT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] source_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [5:0] token_kind, [13:6] text_byte,
                                  // [29:14] token_line, [45:30] token_column,
                                  // [47:46] error_code
  output logic [1:0]  out_tuser,  // [1:0] record_kind
  output logic        out_tlast
);

  localparam int LW = $clog2(TEXT_LIMIT + 1);

  logic [15:0] line_r, col_r, sline_r, scol_r;
  logic [2:0]  cls_r;
  logic [LW-1:0] len_r;
  logic [23:0] mask_r;
  logic        pnl_r, halt_r;

  bsl_pkg::rec_t buf_r [3];
  logic [1:0]    cnt_r, idx_r;

  logic [15:0] line_nxt, col_nxt, sline_nxt, scol_nxt;
  logic [2:0]  cls_nxt;
  logic [LW-1:0] len_nxt;
  logic [23:0] mask_nxt;
  logic        pnl_nxt, halt_nxt;
  bsl_pkg::rec_t rec [3];
  logic [1:0]  n;

  logic [7:0] b, lb;
  logic is_dig, is_let, fresh;
  logic [5:0] symk;
  logic [5:0] p;

  logic last_out, accept;
  assign last_out = (idx_r + 2'd1 == cnt_r);
  assign in_tready = (cnt_r == 2'd0) || (out_tready && last_out);
  assign accept = in_tvalid && in_tready;

  function automatic logic [15:0] sat1(input logic [15:0] a);
    return (a == 16'hFFFF) ? a : a + 16'd1;
  endfunction
  function automatic logic [15:0] sat3(input logic [15:0] a);
    return (a > 16'hFFFC) ? 16'hFFFF : a + 16'd3;
  endfunction

  always_comb begin
    logic [15:0] c;
    logic [15:0] l;
    bsl_pkg::rec_t r;
    r = '0;
    b = in_tdata;
    lb = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    is_dig = b >= "0" && b <= "9";
    is_let = lb >= "a" && lb <= "z";
    c = sat1(col_r);
    l = line_r;
    if (b == 8'd0 || b == 8'h0A) begin l = sat1(line_r); c = 16'd0; end
    if (b == 8'h09) c = sat3(c);
    if (b == 8'h0D) c = 16'd0;
    line_nxt = l; col_nxt = c;
    sline_nxt = sline_r; scol_nxt = scol_r; cls_nxt = cls_r; len_nxt = len_r;
    mask_nxt = mask_r; pnl_nxt = pnl_r; halt_nxt = halt_r;
    n = 2'd0;
    for (int i = 0; i < 3; i++) rec[i] = '0;
    fresh = 1'b1;
    symk = bsl_pkg::TK_SYM;
    if (len_r <= LW'(8)) begin
      for (int k = bsl_pkg::KW_COUNT - 1; k >= 0; k--) begin
        if (mask_r[k] && LW'(bsl_pkg::kw_len(5'(k))) == len_r)
          symk = bsl_pkg::TK_KW0 + 6'(k);
      end
    end
    p = 6'd0;
    case (b)
      ",": p = bsl_pkg::TK_COMMA;
      "(": p = bsl_pkg::TK_LPAREN;
      ")": p = bsl_pkg::TK_RPAREN;
      "+": p = bsl_pkg::TK_PLUS;
      "-": p = bsl_pkg::TK_MINUS;
      "/": p = bsl_pkg::TK_SLASH;
      "*": p = bsl_pkg::TK_STAR;
      "=": p = bsl_pkg::TK_EQ;
      default: p = 6'd0;
    endcase

    if (halt_r) begin
      fresh = 1'b0;
      if (b == 8'd0) begin
        rec[0] = '{bsl_pkg::REC_TOKEN, bsl_pkg::TK_END, 8'd0, l, c, 2'd0};
        n = 2'd1;
        line_nxt = 16'd1; col_nxt = 16'd0; cls_nxt = bsl_pkg::CL_IDLE; len_nxt = '0;
        mask_nxt = '1; sline_nxt = '0; scol_nxt = '0; pnl_nxt = 1'b0; halt_nxt = 1'b0;
      end
    end else begin
      r = '{bsl_pkg::REC_TOKEN, 6'd0, 8'd0, sline_r, scol_r, 2'd0};
      case (cls_r)
        bsl_pkg::CL_STR: begin
          fresh = 1'b0;
          if (b == 8'h22) begin
            r.tok = bsl_pkg::TK_STR; rec[0] = r; n = 2'd1;
            pnl_nxt = 1'b0; cls_nxt = bsl_pkg::CL_IDLE;
          end else if (b == 8'd0) begin
            rec[0] = '{bsl_pkg::REC_ERROR, 6'd0, 8'd0, l, c, bsl_pkg::ERR_UNTERM};
            rec[1] = '{bsl_pkg::REC_TOKEN, bsl_pkg::TK_END, 8'd0, l, c, 2'd0};
            n = 2'd2;
            line_nxt = 16'd1; col_nxt = 16'd0; cls_nxt = bsl_pkg::CL_IDLE; len_nxt = '0;
            mask_nxt = '1; sline_nxt = '0; scol_nxt = '0; pnl_nxt = 1'b0;
          end else begin
            n = 2'd1;
            if (32'(len_r) + 1 >= TEXT_LIMIT) begin
              rec[0] = '{bsl_pkg::REC_ERROR, 6'd0, 8'd0, l, c, bsl_pkg::ERR_LONG};
              halt_nxt = 1'b1; cls_nxt = bsl_pkg::CL_IDLE;
            end else begin
              rec[0] = '{bsl_pkg::REC_TEXT, bsl_pkg::TK_STR, b, sline_r, scol_r, 2'd0};
              len_nxt = len_r + LW'(1);
            end
          end
        end
        bsl_pkg::CL_INT, bsl_pkg::CL_SYM: begin
          if ((cls_r == bsl_pkg::CL_INT && is_dig) ||
              (cls_r == bsl_pkg::CL_SYM && (is_let || is_dig || b == "." || b == "_"))) begin
            fresh = 1'b0; n = 2'd1;
            if (32'(len_r) + 1 >= TEXT_LIMIT) begin
              rec[0] = '{bsl_pkg::REC_ERROR, 6'd0, 8'd0, l, c, bsl_pkg::ERR_LONG};
              halt_nxt = 1'b1; cls_nxt = bsl_pkg::CL_IDLE;
            end else begin
              if (cls_r == bsl_pkg::CL_SYM) begin
                for (int k = 0; k < bsl_pkg::KW_COUNT; k++)
                  if (len_r >= LW'(8) ||
                      bsl_pkg::kw_char(5'(k), len_r[2:0]) != lb) mask_nxt[k] = 1'b0;
                rec[0] = '{bsl_pkg::REC_TEXT, bsl_pkg::TK_SYM, lb, sline_r, scol_r, 2'd0};
              end else
                rec[0] = '{bsl_pkg::REC_TEXT, bsl_pkg::TK_INT, b, sline_r, scol_r, 2'd0};
              len_nxt = len_r + LW'(1);
            end
          end else begin
            r.tok = (cls_r == bsl_pkg::CL_INT) ? bsl_pkg::TK_INT : symk;
            rec[0] = r; n = 2'd1; pnl_nxt = 1'b0; cls_nxt = bsl_pkg::CL_IDLE;
          end
        end
        bsl_pkg::CL_LT: begin
          cls_nxt = bsl_pkg::CL_IDLE; n = 2'd1; pnl_nxt = 1'b0;
          if (b == ">") begin fresh = 1'b0; r.tok = bsl_pkg::TK_NE; end
          else if (b == "=") begin fresh = 1'b0; r.tok = bsl_pkg::TK_LE; end
          else r.tok = bsl_pkg::TK_LT;
          rec[0] = r;
        end
        bsl_pkg::CL_GT: begin
          cls_nxt = bsl_pkg::CL_IDLE; n = 2'd1; pnl_nxt = 1'b0;
          if (b == "=") begin fresh = 1'b0; r.tok = bsl_pkg::TK_GE; end
          else r.tok = bsl_pkg::TK_GT;
          rec[0] = r;
        end
        default: cls_nxt = bsl_pkg::CL_IDLE;
      endcase

      if (fresh) begin
        // lex the byte afresh, after any token flushed above
        r = '{bsl_pkg::REC_TOKEN, 6'd0, 8'd0, l, c, 2'd0};
        if (b == 8'd0) begin
          if (!pnl_nxt) begin
            r.tok = bsl_pkg::TK_NEWLINE; rec[n] = r; n = n + 2'd1;
          end
          r.tok = bsl_pkg::TK_END; rec[n] = r; n = n + 2'd1;
          line_nxt = 16'd1; col_nxt = 16'd0; cls_nxt = bsl_pkg::CL_IDLE; len_nxt = '0;
          mask_nxt = '1; sline_nxt = '0; scol_nxt = '0; pnl_nxt = 1'b0; halt_nxt = 1'b0;
        end else if (b == " " || b == 8'h09 || b == 8'h0D) begin
        end else if (b == 8'h0A) begin
          r.tok = bsl_pkg::TK_NEWLINE; rec[n] = r; n = n + 2'd1; pnl_nxt = 1'b1;
        end else if (b == 8'h22 || b == "<" || b == ">") begin
          cls_nxt = (b == 8'h22) ? bsl_pkg::CL_STR :
                    (b == "<") ? bsl_pkg::CL_LT : bsl_pkg::CL_GT;
          len_nxt = '0; mask_nxt = '1; sline_nxt = l; scol_nxt = c;
        end else if (p != 6'd0) begin
          r.tok = p; rec[n] = r; n = n + 2'd1; pnl_nxt = 1'b0;
        end else if (is_dig || is_let || b == "_") begin
          sline_nxt = l; scol_nxt = c; len_nxt = LW'(1);
          if (is_dig) begin
            cls_nxt = bsl_pkg::CL_INT; mask_nxt = '1;
            rec[n] = '{bsl_pkg::REC_TEXT, bsl_pkg::TK_INT, b, l, c, 2'd0};
          end else begin
            cls_nxt = bsl_pkg::CL_SYM;
            for (int k = 0; k < bsl_pkg::KW_COUNT; k++)
              mask_nxt[k] = (bsl_pkg::kw_char(5'(k), 3'd0) == lb);
            rec[n] = '{bsl_pkg::REC_TEXT, bsl_pkg::TK_SYM, lb, l, c, 2'd0};
          end
          n = n + 2'd1;
        end else begin
          rec[n] = '{bsl_pkg::REC_ERROR, 6'd0, b, l, c, bsl_pkg::ERR_UNKNOWN};
          n = n + 2'd1; halt_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= 16'd1; col_r <= '0; sline_r <= '0; scol_r <= '0;
      cls_r <= bsl_pkg::CL_IDLE; len_r <= '0; mask_r <= '1;
      pnl_r <= 1'b0; halt_r <= 1'b0; cnt_r <= '0; idx_r <= '0;
    end else if (accept) begin
      line_r <= line_nxt; col_r <= col_nxt; sline_r <= sline_nxt; scol_r <= scol_nxt;
      cls_r <= cls_nxt; len_r <= len_nxt; mask_r <= mask_nxt;
      pnl_r <= pnl_nxt; halt_r <= halt_nxt;
      cnt_r <= n; idx_r <= '0;
    end else if (out_tvalid && out_tready) begin
      if (last_out) begin
        cnt_r <= '0; idx_r <= '0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) buf_r[i] <= rec[i];
    end
  end

  bsl_pkg::rec_t cur;
  assign cur = buf_r[idx_r];
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tuser  = cur.kind;
  assign out_tlast  = last_out;
  assign out_tdata  = {cur.err, cur.col, cur.ln, cur.text, cur.tok};

`ifndef NO_ASSERTIONS
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> idx_r < cnt_r) else $error("read index past buffer fill");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) &&
                                     $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled record changed");
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && halt_r && in_tdata != 8'd0) |=> !out_tvalid)
    else $error("halted lexer emitted a record");
  a_reset_line: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tdata == 8'd0) |=> (line_r == 16'd1 && cls_r == bsl_pkg::CL_IDLE))
    else $error("end of input did not reset state");
`endif

endmodule
